// ----- rtl/csp_pkg.sv -----
`default_nettype none
package csp_pkg;

  localparam int MAX_TERMS  = 32;
  localparam int COEF_WIDTH = 32;

  localparam int FRAC_BITS = 16;
  localparam int EXP_W     = 16;
  localparam int PEXP_W    = EXP_W + 1;
  localparam int TERM_W    = 5;
  localparam int IDX_W     = $clog2(MAX_TERMS);
  localparam int DEG_MAX   = (MAX_TERMS - 1 < 31) ? MAX_TERMS - 1 : 31;

  localparam int PROD_W    = 2 * COEF_WIDTH;
  localparam int SCALED_W  = PROD_W - FRAC_BITS;
  localparam int ACC_W     = SCALED_W + TERM_W + 2;

  localparam int IN_FIELDS_W  = 4 * COEF_WIDTH + 2 * EXP_W;
  localparam int IN_TDATA_W   = ((IN_FIELDS_W + 7) / 8) * 8;
  localparam int OUT_FIELDS_W = 2 * COEF_WIDTH + PEXP_W + TERM_W;
  localparam int OUT_TDATA_W  = ((OUT_FIELDS_W + 7) / 8) * 8;

  typedef struct packed {
    logic                  valid;
    logic [COEF_WIDTH-1:0] xr;
    logic [COEF_WIDTH-1:0] xi;
    logic [COEF_WIDTH-1:0] yr;
    logic [COEF_WIDTH-1:0] yi;
  } csp_term_t;

  typedef struct packed {
    logic clear;
    logic busy;
  } csp_mac_stat_t;

endpackage
`default_nettype wire

// ----- rtl/complex_series_product.sv -----
// Product of two truncated complex power series, one coefficient pair per request.
// Input channel in_*: request k carries coefficient k of both series (Q15.16) and,
// for k = 0, the two leading exponents. Output channel out_*: product coefficient
// k (saturated Q15.16), the exponent sum, k itself, and tlast on the term whose
// index equals the programmed degree; the next request then starts a new series.
// cfg_*: writes the degree register (reset 7); write it only while idle.
// Each term is a run of complex multiply-accumulates, one per cycle, through the
// four-multiplier unit fed by the coefficient store; the run passes the store
// read register, the product registers and the accumulator to the result register.
// in_tready is high only while no term is in work, so a new request is accepted
// only after the previous term's result has been loaded into the output register.
// A finished result sits in the output register; the next request is accepted
// while it waits, but its result is held in the unit until out_tready frees it.
// Reset (rst_n low, synchronous) clears the term counter, the exponent, the
// output valid and the sequencer; the coefficient store keeps its contents,
// and term k only reads entries written earlier in the same series.
`default_nettype none
module complex_series_product
  import csp_pkg::*;
(
  input  wire logic                   clk,
  input  wire logic                   rst_n,
  input  wire logic                   in_tvalid,
  output logic                        in_tready,
  // x_real, x_imag, y_real, y_imag, x_lead_exponent, y_lead_exponent
  input  wire logic [IN_TDATA_W-1:0]  in_tdata,
  output logic                        out_tvalid,
  input  wire logic                   out_tready,
  // z_real, z_imag, product_exponent, term_index, zero fill
  output logic [OUT_TDATA_W-1:0]      out_tdata,
  output logic                        out_tlast,
  input  wire logic                   cfg_valid,
  output logic                        cfg_ready,
  input  wire logic [TERM_W-1:0]      cfg_data
);

  typedef enum logic [2:0] {
    ST_IDLE  = 3'b001,
    ST_RUN   = 3'b010,
    ST_DRAIN = 3'b100
  } csp_state_t;

  csp_state_t              state_r, state_nxt;
  logic [TERM_W-1:0]       degree_r;
  logic [TERM_W-1:0]       term_cnt_r;
  logic [TERM_W-1:0]       k_r, idx_r;
  logic                    last_r;
  logic [PEXP_W-1:0]       exp_r;
  logic [TERM_W-1:0]       deg_eff, k_new;
  logic                    in_fire, load_out;
  logic                    out_tvalid_r, out_last_r;
  logic [OUT_FIELDS_W-1:0] out_data_r;
  logic signed [COEF_WIDTH-1:0] z_real, z_imag;
  logic signed [EXP_W-1:0] x_exp, y_exp;
  csp_term_t               term;
  csp_mac_stat_t           mac;

  assign cfg_ready = 1'b1;
  assign in_tready = (state_r == ST_IDLE);
  assign in_fire   = in_tvalid && in_tready;

  assign deg_eff = (degree_r > TERM_W'(DEG_MAX)) ? TERM_W'(DEG_MAX) : degree_r;
  assign k_new   = (term_cnt_r > deg_eff) ? '0 : term_cnt_r;

  assign x_exp = in_tdata[4*COEF_WIDTH +: EXP_W];
  assign y_exp = in_tdata[4*COEF_WIDTH+EXP_W +: EXP_W];

  assign mac.clear = in_fire;

  assign load_out = (state_r == ST_DRAIN) && !term.valid && !mac.busy &&
                    (!out_tvalid_r || out_tready);

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (in_fire) state_nxt = ST_RUN;
      end
      ST_RUN: begin
        if (idx_r == k_r) state_nxt = ST_DRAIN;
      end
      ST_DRAIN: begin
        if (load_out) state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      degree_r     <= TERM_W'(7);
      term_cnt_r   <= '0;
      exp_r        <= '0;
      out_tvalid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (cfg_valid && cfg_ready) degree_r <= cfg_data;
      if (in_fire) begin
        term_cnt_r <= (k_new == deg_eff) ? '0 : k_new + TERM_W'(1);
        if (k_new == '0) exp_r <= PEXP_W'(x_exp) + PEXP_W'(y_exp);
      end
      if (load_out) begin
        out_tvalid_r <= 1'b1;
      end else if (out_tready) begin
        out_tvalid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      k_r    <= k_new;
      last_r <= (k_new == deg_eff);
      idx_r  <= '0;
    end else if (state_r == ST_RUN) begin
      idx_r <= idx_r + TERM_W'(1);
    end
    if (load_out) begin
      out_data_r <= {k_r, exp_r, z_imag, z_real};
      out_last_r <= last_r;
    end
  end

  csp_coef_store u_store (
    .clk       (clk),
    .rst_n     (rst_n),
    .wr_en     (in_fire),
    .wr_addr   (IDX_W'(k_new)),
    .wr_x      (in_tdata[0 +: 2*COEF_WIDTH]),
    .wr_y      (in_tdata[2*COEF_WIDTH +: 2*COEF_WIDTH]),
    .rd_en     (state_r == ST_RUN),
    .rd_addr_x (IDX_W'(idx_r)),
    .rd_addr_y (IDX_W'(k_r - idx_r)),
    .term      (term)
  );

  csp_cmac u_cmac (
    .clk    (clk),
    .rst_n  (rst_n),
    .clear  (mac.clear),
    .term   (term),
    .busy   (mac.busy),
    .z_real (z_real),
    .z_imag (z_imag)
  );

  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = OUT_TDATA_W'(out_data_r);
  assign out_tlast  = out_last_r;

  ap_accept_runs: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire |=> state_r == ST_RUN)
    else $error("accepted request did not start a run");

  ap_run_ends: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_RUN && idx_r == k_r) |=> state_r == ST_DRAIN)
    else $error("run passed its last term");

  ap_idx_bound: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_RUN |-> idx_r <= k_r)
    else $error("term index beyond current term");

  ap_load_free: assert property (@(posedge clk) disable iff (!rst_n)
    load_out |-> (!term.valid && !mac.busy && (!out_tvalid_r || out_tready)))
    else $error("result loaded over a pending one or before drain");

  ap_last_flag: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid_r |-> (out_last_r == (out_data_r[OUT_FIELDS_W-1 -: TERM_W] == deg_eff)))
    else $error("last flag does not match degree");

endmodule
`default_nettype wire

// ----- rtl/csp_coef_store.sv -----
`default_nettype none
module csp_coef_store
  import csp_pkg::*;
(
  input  wire logic                    clk,
  input  wire logic                    rst_n,
  input  wire logic                    wr_en,
  input  wire logic [IDX_W-1:0]        wr_addr,
  input  wire logic [2*COEF_WIDTH-1:0] wr_x,
  input  wire logic [2*COEF_WIDTH-1:0] wr_y,
  input  wire logic                    rd_en,
  input  wire logic [IDX_W-1:0]        rd_addr_x,
  input  wire logic [IDX_W-1:0]        rd_addr_y,
  output csp_term_t                    term
);

  logic [2*COEF_WIDTH-1:0] x_mem [MAX_TERMS];
  logic [2*COEF_WIDTH-1:0] y_mem [MAX_TERMS];
  logic [2*COEF_WIDTH-1:0] x_rd_r;
  logic [2*COEF_WIDTH-1:0] y_rd_r;
  logic                    rd_v_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      x_mem[wr_addr] <= wr_x;
      y_mem[wr_addr] <= wr_y;
    end
    if (rd_en) begin
      x_rd_r <= x_mem[rd_addr_x];
      y_rd_r <= y_mem[rd_addr_y];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rd_v_r <= 1'b0;
    end else begin
      rd_v_r <= rd_en;
    end
  end

  assign term.valid = rd_v_r;
  assign term.xr    = x_rd_r[COEF_WIDTH-1:0];
  assign term.xi    = x_rd_r[2*COEF_WIDTH-1:COEF_WIDTH];
  assign term.yr    = y_rd_r[COEF_WIDTH-1:0];
  assign term.yi    = y_rd_r[2*COEF_WIDTH-1:COEF_WIDTH];

endmodule
`default_nettype wire

// ----- rtl/csp_cmac.sv -----
`default_nettype none
module csp_cmac
  import csp_pkg::*;
(
  input  wire logic                   clk,
  input  wire logic                   rst_n,
  input  wire logic                   clear,
  input  csp_term_t                   term,
  output logic                        busy,
  output logic signed [COEF_WIDTH-1:0] z_real,
  output logic signed [COEF_WIDTH-1:0] z_imag
);

  logic signed [PROD_W-1:0]   p_rr_r, p_ii_r, p_ir_r, p_ri_r;
  logic                       mul_v_r;
  logic signed [ACC_W-1:0]    acc_re_r, acc_im_r;
  logic signed [ACC_W-1:0]    acc_re_nxt, acc_im_nxt;
  logic signed [SCALED_W-1:0] s_rr, s_ii, s_ir, s_ri;

  always_ff @(posedge clk) begin
    p_rr_r <= $signed(term.xr) * $signed(term.yr);
    p_ii_r <= $signed(term.xi) * $signed(term.yi);
    p_ir_r <= $signed(term.xi) * $signed(term.yr);
    p_ri_r <= $signed(term.xr) * $signed(term.yi);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mul_v_r <= 1'b0;
    end else begin
      mul_v_r <= term.valid;
    end
  end

  // floor shift of each exact product
  assign s_rr = p_rr_r[PROD_W-1:FRAC_BITS];
  assign s_ii = p_ii_r[PROD_W-1:FRAC_BITS];
  assign s_ir = p_ir_r[PROD_W-1:FRAC_BITS];
  assign s_ri = p_ri_r[PROD_W-1:FRAC_BITS];

  always_comb begin
    acc_re_nxt = acc_re_r;
    acc_im_nxt = acc_im_r;
    if (clear) begin
      acc_re_nxt = '0;
      acc_im_nxt = '0;
    end else if (mul_v_r) begin
      acc_re_nxt = acc_re_r + ACC_W'(s_rr) - ACC_W'(s_ii);
      acc_im_nxt = acc_im_r + ACC_W'(s_ir) + ACC_W'(s_ri);
    end
  end

  always_ff @(posedge clk) begin
    acc_re_r <= acc_re_nxt;
    acc_im_r <= acc_im_nxt;
  end

  always_comb begin
    if (acc_re_r[ACC_W-1:COEF_WIDTH-1] != {(ACC_W-COEF_WIDTH+1){acc_re_r[ACC_W-1]}}) begin
      z_real = {acc_re_r[ACC_W-1], {(COEF_WIDTH-1){~acc_re_r[ACC_W-1]}}};
    end else begin
      z_real = acc_re_r[COEF_WIDTH-1:0];
    end
    if (acc_im_r[ACC_W-1:COEF_WIDTH-1] != {(ACC_W-COEF_WIDTH+1){acc_im_r[ACC_W-1]}}) begin
      z_imag = {acc_im_r[ACC_W-1], {(COEF_WIDTH-1){~acc_im_r[ACC_W-1]}}};
    end else begin
      z_imag = acc_im_r[COEF_WIDTH-1:0];
    end
  end

  assign busy = mul_v_r;

endmodule
`default_nettype wire

// ----- tb/complex_series_product_checker.sv -----
`timescale 1ns / 1ps
module complex_series_product_checker
  import csp_pkg::*;
(
  input  wire logic                   clk,
  input  wire logic                   rst_n,
  input  wire logic                   in_tvalid,
  input  wire logic                   in_tready,
  // x_real, x_imag, y_real, y_imag, x_lead_exponent, y_lead_exponent
  input  wire logic [IN_TDATA_W-1:0]  in_tdata,
  input  wire logic                   out_tvalid,
  input  wire logic                   out_tready,
  // z_real, z_imag, product_exponent, term_index, zero fill
  input  wire logic [OUT_TDATA_W-1:0] out_tdata,
  input  wire logic                   out_tlast,
  input  wire logic                   cfg_valid,
  input  wire logic                   cfg_ready,
  input  wire logic [TERM_W-1:0]      cfg_data,
  output int                          failures,
  output int                          outstanding
);

  typedef struct {
    logic [COEF_WIDTH-1:0] re;
    logic [COEF_WIDTH-1:0] im;
    logic [PEXP_W-1:0]     pexp;
    logic [TERM_W-1:0]     idx;
    logic                  last;
  } coef_result_t;

  logic [COEF_WIDTH-1:0] x_re_mem [MAX_TERMS];
  logic [COEF_WIDTH-1:0] x_im_mem [MAX_TERMS];
  logic [COEF_WIDTH-1:0] y_re_mem [MAX_TERMS];
  logic [COEF_WIDTH-1:0] y_im_mem [MAX_TERMS];
  logic [TERM_W-1:0]     next_term = '0;
  logic [TERM_W-1:0]     degree = 5'd7;
  logic [PEXP_W-1:0]     exp_sum = '0;
  coef_result_t          pending_products [$];
  int                    fail_count = 0;

  function automatic longint scaled_mul(input logic [COEF_WIDTH-1:0] a, b);
    longint prod;
    prod = longint'($signed(a)) * longint'($signed(b));
    return prod >>> FRAC_BITS;
  endfunction

  function automatic logic [COEF_WIDTH-1:0] saturate(input longint v);
    longint hi;
    longint lo;
    hi = (longint'(1) <<< (COEF_WIDTH - 1)) - 1;
    lo = -hi - 1;
    if (v > hi) v = hi;
    if (v < lo) v = lo;
    return v[COEF_WIDTH-1:0];
  endfunction

  function automatic coef_result_t predict_coef(input logic [TERM_W-1:0] k,
                                                input logic last);
    coef_result_t r;
    longint re_acc;
    longint im_acc;
    int j;
    re_acc = 0;
    im_acc = 0;
    for (int i = 0; i <= k; i++) begin
      j = k - i;
      re_acc += scaled_mul(x_re_mem[i], y_re_mem[j]) - scaled_mul(x_im_mem[i], y_im_mem[j]);
      im_acc += scaled_mul(x_im_mem[i], y_re_mem[j]) + scaled_mul(x_re_mem[i], y_im_mem[j]);
    end
    r.re = saturate(re_acc);
    r.im = saturate(im_acc);
    r.pexp = exp_sum;
    r.idx = k;
    r.last = last;
    return r;
  endfunction

  task automatic check_field(input string field, input longint unsigned want, got);
    if (want != got) begin
      $display("%0t: %s expected %0h got %0h", $time, field, want, got);
      fail_count++;
    end
  endtask

  always @(posedge clk) begin : watch
    logic [TERM_W-1:0] k;
    logic [TERM_W-1:0] eff_degree;
    coef_result_t want;
    if (!rst_n) begin
      next_term = '0;
      exp_sum = '0;
      degree = 5'd7;
      pending_products.delete();
    end else begin
      if (in_tvalid && in_tready) begin
        eff_degree = (degree > DEG_MAX) ? TERM_W'(DEG_MAX) : degree;
        k = (next_term > eff_degree) ? '0 : next_term;
        x_re_mem[k] = in_tdata[31:0];
        x_im_mem[k] = in_tdata[63:32];
        y_re_mem[k] = in_tdata[95:64];
        y_im_mem[k] = in_tdata[127:96];
        if (k == 0)
          exp_sum = {in_tdata[143], in_tdata[143:128]} + {in_tdata[159], in_tdata[159:144]};
        pending_products.push_back(predict_coef(k, k == eff_degree));
        next_term = (k == eff_degree) ? '0 : k + 1'b1;
      end
      if (cfg_valid && cfg_ready)
        degree = cfg_data;
      if (out_tvalid && out_tready) begin
        if (pending_products.size() == 0) begin
          $display("%0t: result %0h with no request outstanding", $time, out_tdata);
          fail_count++;
        end else begin
          want = pending_products.pop_front();
          check_field("z_real", want.re, out_tdata[31:0]);
          check_field("z_imag", want.im, out_tdata[63:32]);
          check_field("product_exponent", want.pexp, out_tdata[80:64]);
          check_field("term_index", want.idx, out_tdata[85:81]);
          check_field("last_term", want.last, out_tlast);
        end
      end
    end
    outstanding <= pending_products.size();
    failures <= fail_count;
  end

endmodule

// ----- tb/complex_series_product_test.sv -----
`timescale 1ns / 1ps
module complex_series_product_test;
  import csp_pkg::*;

  localparam int ITEM_TARGET = 1700;
  localparam int CYCLE_LIMIT = 1000000;
  localparam int DRAIN_CYCLES = 8;
  localparam int TAIL_CYCLES = 60;

  localparam logic [COEF_WIDTH-1:0] Q_MAX     = 32'h7FFF_FFFF;
  localparam logic [COEF_WIDTH-1:0] Q_MIN     = 32'h8000_0000;
  localparam logic [COEF_WIDTH-1:0] Q_ONE     = 32'h0001_0000;
  localparam logic [COEF_WIDTH-1:0] Q_NEG_ONE = 32'hFFFF_0000;
  localparam logic [COEF_WIDTH-1:0] Q_HALF    = 32'h0000_8000;
  localparam logic [COEF_WIDTH-1:0] Q_LSB     = 32'h0000_0001;
  localparam logic [COEF_WIDTH-1:0] Q_NEG_LSB = 32'hFFFF_FFFF;
  localparam logic [EXP_W-1:0]      E_MAX     = 16'h7FFF;
  localparam logic [EXP_W-1:0]      E_MIN     = 16'h8000;

  typedef enum int {RX_ALWAYS, RX_MOSTLY, RX_HALF, RX_LONG_STALL} rx_mode_t;

  logic                   clk = 1'b0;
  logic                   rst_n = 1'b0;
  logic                   in_tvalid = 1'b0;
  logic                   in_tready;
  logic [IN_TDATA_W-1:0]  in_tdata = '0;
  logic                   out_tvalid;
  logic                   out_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] out_tdata;
  logic                   out_tlast;
  logic                   cfg_valid = 1'b0;
  logic                   cfg_ready;
  logic [TERM_W-1:0]      cfg_data = '0;

  int       failures;
  int       outstanding;
  int       cycle_count = 0;
  int       items_sent = 0;
  int       burst_left = 0;
  int       rx_run = 0;
  rx_mode_t rx_mode = RX_ALWAYS;

  complex_series_product uut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_data   (cfg_data)
  );

  complex_series_product_checker checker_i (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .in_tdata    (in_tdata),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata),
    .out_tlast   (out_tlast),
    .cfg_valid   (cfg_valid),
    .cfg_ready   (cfg_ready),
    .cfg_data    (cfg_data),
    .failures    (failures),
    .outstanding (outstanding)
  );

  always #5 clk = ~clk;

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (rx_run == 0) begin
      rx_mode = rx_mode_t'($urandom_range(0, 3));
      rx_run = $urandom_range(50, 400);
    end else begin
      rx_run--;
    end
    case (rx_mode)
      RX_ALWAYS: out_tready <= 1'b1;
      RX_MOSTLY: out_tready <= ($urandom_range(0, 3) != 0);
      RX_HALF: out_tready <= 1'($urandom_range(0, 1));
      default: out_tready <= ((rx_run % 24) < 6);
    endcase
  end

  function automatic logic [COEF_WIDTH-1:0] rand_coef();
    logic [31:0] r;
    r = $urandom;
    case ($urandom_range(0, 7))
      0: return Q_MAX;
      1: return Q_MIN;
      2: return '0;
      3: return {{14{r[17]}}, r[17:0]};
      default: return r;
    endcase
  endfunction

  task automatic pace();
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 60) : $urandom_range(0, 12);
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 15)) @(posedge clk);
    end
  endtask

  task automatic send_coef(input logic [COEF_WIDTH-1:0] xr, xi, yr, yi,
                           input logic [EXP_W-1:0] xe, ye);
    in_tvalid <= 1'b1;
    in_tdata <= {ye, xe, yi, yr, xi, xr};
    do @(posedge clk); while (!in_tready);
    items_sent++;
    pace();
  endtask

  task automatic send_random(input bit real_only);
    logic [COEF_WIDTH-1:0] xi;
    logic [COEF_WIDTH-1:0] yi;
    xi = real_only ? '0 : rand_coef();
    yi = real_only ? '0 : rand_coef();
    send_coef(rand_coef(), xi, rand_coef(), yi, EXP_W'($urandom), EXP_W'($urandom));
  endtask

  // drain every outstanding request before touching the degree
  task automatic write_degree(input logic [TERM_W-1:0] deg);
    in_tvalid <= 1'b0;
    do @(posedge clk); while (outstanding != 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_data <= deg;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
  endtask

  initial begin
    int phase_no;
    int pick;
    int series;
    int count;
    logic [TERM_W-1:0] deg;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // reset degree of 7: extremes, rounding, real product
    send_coef(Q_MAX, Q_MAX, Q_MAX, Q_MAX, E_MAX, E_MAX);
    send_coef(Q_MIN, Q_MIN, Q_MIN, Q_MIN, E_MIN, E_MIN);
    send_coef(Q_MAX, Q_MIN, Q_MIN, Q_MAX, '0, '0);
    send_coef(Q_ONE, '0, Q_ONE, '0, '0, '0);
    send_coef(Q_NEG_ONE, '0, Q_HALF, '0, '0, '0);
    send_coef(Q_LSB, Q_LSB, Q_NEG_LSB, Q_LSB, '0, '0);
    send_coef('0, '0, '0, '0, '0, '0);
    send_random(1'b0);
    send_coef(Q_ONE, Q_NEG_ONE, Q_HALF, Q_ONE, E_MIN, E_MIN);
    repeat (4) send_random(1'b0);

    // lower the degree mid-series: next request restarts at term 0
    write_degree(5'd2);
    repeat (3) send_random(1'b0);

    write_degree(5'd0);
    send_coef(Q_MAX, Q_MIN, Q_MAX, Q_MIN, E_MAX, E_MIN);
    send_coef(Q_MIN, Q_MAX, Q_MIN, Q_MAX, E_MIN, E_MAX);
    send_coef(Q_ONE, '0, Q_NEG_ONE, '0, E_MIN, E_MIN);

    phase_no = 0;
    while (items_sent < ITEM_TARGET) begin
      pick = $urandom_range(0, 9);
      if (phase_no == 0)
        deg = 5'd31;
      else if (phase_no == 1)
        deg = 5'd0;
      else if (pick < 6)
        deg = TERM_W'($urandom_range(0, 7));
      else if (pick < 8)
        deg = TERM_W'($urandom_range(8, 31));
      else
        deg = 5'd31;
      write_degree(deg);
      series = (deg > 15) ? 1 : $urandom_range(1, 4);
      count = series * (deg + 1);
      if ($urandom_range(0, 2) == 0)
        count += $urandom_range(0, deg);
      repeat (count) send_random($urandom_range(0, 7) == 0);
      phase_no++;
    end

    in_tvalid <= 1'b0;
    do @(posedge clk); while (outstanding != 0);
    repeat (TAIL_CYCLES) @(posedge clk);
    if (failures == 0)
      $display("ALL CHECKS PASSED");
    else
      $display("CHECKS FAILED");
    $finish;
  end

endmodule

// ----- files.f -----
rtl/csp_pkg.sv
rtl/csp_coef_store.sv
rtl/csp_cmac.sv
rtl/complex_series_product.sv
tb/complex_series_product_checker.sv
tb/complex_series_product_test.sv
